/* design/ook_remote_switch_transmitter_macros.svh */
// assertion helpers used by the asserting top-level file
`ifndef OOK_REMOTE_SWITCH_TRANSMITTER_MACROS_SVH
`define OOK_REMOTE_SWITCH_TRANSMITTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define OOKSW_ASSERT_NOW(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |-> (rhs)) \
        else $error("ooksw same-cycle check failed");

// next-cycle implication, checked outside reset
`define OOKSW_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |=> (rhs)) \
        else $error("ooksw next-cycle check failed");

`endif

/* design/ooksw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ooksw_pkg;

    // fixed frame geometry
    localparam int WIRE_PULSES = 64;
    localparam int IDX_W       = 6;
    localparam logic [IDX_W-1:0] LAST_PULSE = IDX_W'(WIRE_PULSES - 1);

    // field widths
    localparam int ID_W   = 26;
    localparam int DUR_W  = 16;
    localparam int REP_W  = 4;
    localparam int MSG_W  = 32;
    localparam int CFG_DW = 26;

    // register reset values
    localparam logic [ID_W-1:0]  RST_REMOTE_ID    = ID_W'(34937088);
    localparam logic [DUR_W-1:0] RST_HIGH_PULSE   = DUR_W'(275);
    localparam logic [DUR_W-1:0] RST_SHORT_LOW    = DUR_W'(275);
    localparam logic [DUR_W-1:0] RST_LONG_LOW     = DUR_W'(1225);
    localparam logic [DUR_W-1:0] RST_FIRST_LATCH  = DUR_W'(9900);
    localparam logic [DUR_W-1:0] RST_SECOND_LATCH = DUR_W'(2675);
    localparam logic [DUR_W-1:0] RST_FRAME_GAP    = DUR_W'(10000);
    localparam logic [REP_W-1:0] RST_REPEAT       = REP_W'(3);

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_REMOTE_ID     = 3'd0,
        CFG_HIGH_PULSE    = 3'd1,
        CFG_SHORT_LOW     = 3'd2,
        CFG_LONG_LOW      = 3'd3,
        CFG_FIRST_LATCH   = 3'd4,
        CFG_SECOND_LATCH  = 3'd5,
        CFG_FRAME_GAP     = 3'd6,
        CFG_REPEAT        = 3'd7
    } t_cfg_idx;

    // waveform segments
    typedef enum logic [3:0] {
        SEG_IDLE      = 4'd0,
        SEG_L1_HIGH   = 4'd1,
        SEG_L1_LOW    = 4'd2,
        SEG_L2A_HIGH  = 4'd3,
        SEG_L2A_LOW   = 4'd4,
        SEG_DATA_HIGH = 4'd5,
        SEG_DATA_LOW  = 4'd6,
        SEG_L2B_HIGH  = 4'd7,
        SEG_L2B_LOW   = 4'd8,
        SEG_GAP       = 4'd9
    } t_seg;

    // configuration bundle
    typedef struct packed {
        logic [ID_W-1:0]  remote_id;
        logic [DUR_W-1:0] high_pulse;
        logic [DUR_W-1:0] short_low;
        logic [DUR_W-1:0] long_low;
        logic [DUR_W-1:0] first_latch;
        logic [DUR_W-1:0] second_latch;
        logic [DUR_W-1:0] frame_gap;
        logic [REP_W-1:0] repeat_cnt;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic tx_level;
        logic led_level;
        logic busy_res;
        logic accepted;
    } t_result;

endpackage

`default_nettype wire

/* design/ook_remote_switch_transmitter.sv */
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------------------
// in       | in        | i_in_valid / o_in_ready    | command, group_flag, on_flag, dev_num
// out      | out       | o_out_valid / i_out_ready  | tx_level, led_level, busy_res, accepted
// cfg      | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// one item per cycle while the output is not stalled: the segment sequencer steps once per input transfer
// the result sits in the output register the cycle after its transfer
// input is ready while the output register is empty or being taken
// a stalled output holds the sequencer, nothing is dropped
// reset idles the sequencer and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "ook_remote_switch_transmitter_macros.svh"

module ook_remote_switch_transmitter #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_command,
    input  wire logic                         i_group_flag,
    input  wire logic                         i_on_flag,
    input  wire logic [3:0]                   i_dev_num,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_tx_level,
    output logic                              o_led_level,
    output logic                              o_busy_res,
    output logic                              o_accepted,
    input  wire logic                         i_cfg_we,
    input  wire logic [2:0]                   i_cfg_index,
    input  wire logic [ooksw_pkg::CFG_DW-1:0] i_cfg_data
);

    ooksw_pkg::t_cfg    cfg;
    ooksw_pkg::t_result step_res;
    ooksw_pkg::t_result out_res;
    logic               in_fire;

    // input transfer
    assign o_in_ready = !o_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // configuration registers
    ooksw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // segment sequencer
    ooksw_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_command     (i_command),
        .i_group_flag  (i_group_flag),
        .i_on_flag     (i_on_flag),
        .i_dev_num     (i_dev_num),
        .i_cfg         (cfg),
        .o_res         (step_res)
    );

    // result register
    ooksw_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_fire),
        .i_res       (step_res),
        .i_out_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    assign o_tx_level  = out_res.tx_level;
    assign o_led_level = out_res.led_level;
    assign o_busy_res  = out_res.busy_res;
    assign o_accepted  = out_res.accepted;

    // checks
    `OOKSW_ASSERT_NOW(a_accept_busy, o_out_valid && o_accepted, o_busy_res)
    `OOKSW_ASSERT_NOW(a_led_busy, o_out_valid && o_led_level, o_busy_res)
    `OOKSW_ASSERT_NOW(a_tx_led, o_out_valid && o_tx_level, o_led_level)
    `OOKSW_ASSERT_NEXT(a_fire_valid, in_fire, o_out_valid)

endmodule

`default_nettype wire

/* design/ooksw_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module ooksw_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [2:0]                   i_cfg_index,
    input  wire logic [ooksw_pkg::CFG_DW-1:0] i_cfg_data,
    output ooksw_pkg::t_cfg                   o_cfg
);

    ooksw_pkg::t_cfg r_cfg;

    // register file, one write per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.remote_id     <= ooksw_pkg::RST_REMOTE_ID;
            r_cfg.high_pulse    <= ooksw_pkg::RST_HIGH_PULSE;
            r_cfg.short_low     <= ooksw_pkg::RST_SHORT_LOW;
            r_cfg.long_low      <= ooksw_pkg::RST_LONG_LOW;
            r_cfg.first_latch   <= ooksw_pkg::RST_FIRST_LATCH;
            r_cfg.second_latch  <= ooksw_pkg::RST_SECOND_LATCH;
            r_cfg.frame_gap     <= ooksw_pkg::RST_FRAME_GAP;
            r_cfg.repeat_cnt    <= ooksw_pkg::RST_REPEAT;
        end else if (i_cfg_we) begin
            unique case (ooksw_pkg::t_cfg_idx'(i_cfg_index))
                ooksw_pkg::CFG_REMOTE_ID: begin
                    r_cfg.remote_id <= i_cfg_data[ooksw_pkg::ID_W-1:0];
                end
                ooksw_pkg::CFG_HIGH_PULSE: begin
                    r_cfg.high_pulse <= i_cfg_data[ooksw_pkg::DUR_W-1:0];
                end
                ooksw_pkg::CFG_SHORT_LOW: begin
                    r_cfg.short_low <= i_cfg_data[ooksw_pkg::DUR_W-1:0];
                end
                ooksw_pkg::CFG_LONG_LOW: begin
                    r_cfg.long_low <= i_cfg_data[ooksw_pkg::DUR_W-1:0];
                end
                ooksw_pkg::CFG_FIRST_LATCH: begin
                    r_cfg.first_latch <= i_cfg_data[ooksw_pkg::DUR_W-1:0];
                end
                ooksw_pkg::CFG_SECOND_LATCH: begin
                    r_cfg.second_latch <= i_cfg_data[ooksw_pkg::DUR_W-1:0];
                end
                ooksw_pkg::CFG_FRAME_GAP: begin
                    r_cfg.frame_gap <= i_cfg_data[ooksw_pkg::DUR_W-1:0];
                end
                ooksw_pkg::CFG_REPEAT: begin
                    r_cfg.repeat_cnt <= i_cfg_data[ooksw_pkg::REP_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/ooksw_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module ooksw_seq #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic            i_command,
    input  wire logic            i_group_flag,
    input  wire logic            i_on_flag,
    input  wire logic [3:0]      i_dev_num,
    input  wire ooksw_pkg::t_cfg i_cfg,
    output ooksw_pkg::t_result   o_res
);

    // compare width wide enough for both a register value and the timer limit
    localparam int CW = (TIMER_BITS > ooksw_pkg::DUR_W) ? TIMER_BITS : ooksw_pkg::DUR_W;
    localparam logic [CW-1:0] TMAX = CW'((64'd1 << TIMER_BITS) - 64'd1);

    logic [ooksw_pkg::MSG_W-1:0] r_msg, n_msg;
    ooksw_pkg::t_seg             r_seg, n_seg;
    logic [ooksw_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [ooksw_pkg::REP_W-1:0] r_frames, n_frames;
    logic [TIMER_BITS-1:0]       r_cnt, n_cnt;
    logic                        r_busy, n_busy;

    logic                        load;
    logic                        accepted;
    logic [TIMER_BITS-1:0]       cnt_dec;
    logic [ooksw_pkg::REP_W-1:0] frames_inc;
    logic [ooksw_pkg::REP_W-1:0] reps;
    logic [4:0]                  bit_pos;
    logic                        is_long;
    logic [ooksw_pkg::DUR_W-1:0] dur;
    logic [CW-1:0]               dur_ext;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg    <= '0;
            r_seg    <= ooksw_pkg::SEG_IDLE;
            r_idx    <= '0;
            r_frames <= '0;
            r_cnt    <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_msg    <= n_msg;
            r_seg    <= n_seg;
            r_idx    <= n_idx;
            r_frames <= n_frames;
            r_cnt    <= n_cnt;
            r_busy   <= n_busy;
        end
    end

    // segment step for one transfer
    always_comb begin
        n_msg      = r_msg;
        n_seg      = r_seg;
        n_idx      = r_idx;
        n_frames   = r_frames;
        n_cnt      = r_cnt;
        n_busy     = r_busy;
        load       = 1'b0;
        accepted   = 1'b0;
        cnt_dec    = r_cnt - TIMER_BITS'(1);
        frames_inc = r_frames + ooksw_pkg::REP_W'(1);
        reps       = (i_cfg.repeat_cnt == '0) ? ooksw_pkg::REP_W'(1) : i_cfg.repeat_cnt;

        if (i_fire) begin
            if (i_command) begin
                // send request, refused while busy
                if (!r_busy) begin
                    n_msg    = {i_cfg.remote_id, i_group_flag, i_on_flag, i_dev_num};
                    n_busy   = 1'b1;
                    n_frames = '0;
                    n_idx    = '0;
                    n_seg    = ooksw_pkg::SEG_L1_HIGH;
                    load     = 1'b1;
                    accepted = 1'b1;
                end
            end else if (r_busy) begin
                // unused segment codes fall back to idle
                priority if ((r_seg == ooksw_pkg::SEG_IDLE) ||
                             (r_seg > ooksw_pkg::SEG_GAP)) begin
                    n_seg  = ooksw_pkg::SEG_IDLE;
                    n_busy = 1'b0;
                    n_cnt  = '0;
                    n_idx  = '0;
                end else begin
                    n_cnt = cnt_dec;
                    if (cnt_dec == '0) begin
                        load = 1'b1;
                        unique case (r_seg)
                            ooksw_pkg::SEG_L1_HIGH:   n_seg = ooksw_pkg::SEG_L1_LOW;
                            ooksw_pkg::SEG_L1_LOW:    n_seg = ooksw_pkg::SEG_L2A_HIGH;
                            ooksw_pkg::SEG_L2A_HIGH:  n_seg = ooksw_pkg::SEG_L2A_LOW;
                            ooksw_pkg::SEG_L2A_LOW: begin
                                n_idx = '0;
                                n_seg = ooksw_pkg::SEG_DATA_HIGH;
                            end
                            ooksw_pkg::SEG_DATA_HIGH: n_seg = ooksw_pkg::SEG_DATA_LOW;
                            ooksw_pkg::SEG_DATA_LOW: begin
                                if (r_idx >= ooksw_pkg::LAST_PULSE) begin
                                    n_idx = '0;
                                    n_seg = ooksw_pkg::SEG_L2B_HIGH;
                                end else begin
                                    n_idx = r_idx + ooksw_pkg::IDX_W'(1);
                                    n_seg = ooksw_pkg::SEG_DATA_HIGH;
                                end
                            end
                            ooksw_pkg::SEG_L2B_HIGH:  n_seg = ooksw_pkg::SEG_L2B_LOW;
                            ooksw_pkg::SEG_L2B_LOW:   n_seg = ooksw_pkg::SEG_GAP;
                            ooksw_pkg::SEG_GAP: begin
                                n_frames = frames_inc;
                                if (frames_inc >= reps) begin
                                    load   = 1'b0;
                                    n_seg  = ooksw_pkg::SEG_IDLE;
                                    n_busy = 1'b0;
                                    n_cnt  = '0;
                                    n_idx  = '0;
                                end else begin
                                    n_seg = ooksw_pkg::SEG_L1_HIGH;
                                end
                            end
                            default: begin
                                load   = 1'b0;
                                n_seg  = ooksw_pkg::SEG_IDLE;
                                n_busy = 1'b0;
                                n_cnt  = '0;
                                n_idx  = '0;
                            end
                        endcase
                    end
                end
            end
        end

        // duration of the segment being entered
        bit_pos = 5'd31 - n_idx[5:1];
        is_long = r_msg[bit_pos] ^ n_idx[0];
        unique case (n_seg)
            ooksw_pkg::SEG_L1_HIGH,
            ooksw_pkg::SEG_L2A_HIGH,
            ooksw_pkg::SEG_DATA_HIGH,
            ooksw_pkg::SEG_L2B_HIGH:  dur = i_cfg.high_pulse;
            ooksw_pkg::SEG_L1_LOW:    dur = i_cfg.first_latch;
            ooksw_pkg::SEG_L2A_LOW,
            ooksw_pkg::SEG_L2B_LOW:   dur = i_cfg.second_latch;
            ooksw_pkg::SEG_DATA_LOW:  dur = is_long ? i_cfg.long_low : i_cfg.short_low;
            ooksw_pkg::SEG_GAP:       dur = i_cfg.frame_gap;
            default:                  dur = '0;
        endcase

        // zero counts as one tick, saturate at the timer limit
        dur_ext = CW'(dur);
        if (load) begin
            priority if (dur_ext == '0) begin
                n_cnt = TIMER_BITS'(1);
            end else if (dur_ext > TMAX) begin
                n_cnt = '1;
            end else begin
                n_cnt = dur_ext[TIMER_BITS-1:0];
            end
        end
    end

    // levels after this item
    always_comb begin
        o_res.tx_level  = (n_seg == ooksw_pkg::SEG_L1_HIGH)   ||
                          (n_seg == ooksw_pkg::SEG_L2A_HIGH)  ||
                          (n_seg == ooksw_pkg::SEG_DATA_HIGH) ||
                          (n_seg == ooksw_pkg::SEG_L2B_HIGH);
        o_res.led_level = (n_seg >= ooksw_pkg::SEG_L1_HIGH) &&
                          (n_seg <= ooksw_pkg::SEG_L2B_LOW);
        o_res.busy_res  = n_busy;
        o_res.accepted  = accepted;
    end

endmodule

`default_nettype wire

/* design/ooksw_out.sv */
`timescale 1ns / 1ps
`default_nettype none

module ooksw_out (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire ooksw_pkg::t_result i_res,
    input  wire logic               i_out_ready,
    output logic                    o_valid,
    output ooksw_pkg::t_result      o_res
);

    logic               r_valid, n_valid;
    ooksw_pkg::t_result r_res;

    // hold until the result transfer completes
    assign n_valid = i_load || (r_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire
